[rtl/sc2a_pkg.sv]
// Shared types, constants and the make-code table for the scan-code decoder.
package sc2a_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);

    localparam logic [7:0] CODE_EXTENDED = 8'hE0;
    localparam logic [7:0] CODE_UP       = 8'h48;
    localparam logic [7:0] CODE_DOWN     = 8'h50;

    localparam logic [6:0] CHAR_NONE = 7'h00;
    localparam logic [6:0] CHAR_UP   = 7'h01;
    localparam logic [6:0] CHAR_DOWN = 7'h02;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic       valid;
        logic [6:0] ch;
    } t_push;

    // set 1 make code to character, CHAR_NONE where unmapped
    function automatic logic [6:0] make_char(input logic [6:0] code);
        logic [6:0] c;
        case (code)
            7'h1E: c = 7'h61;  // a
            7'h30: c = 7'h62;
            7'h2E: c = 7'h63;
            7'h20: c = 7'h64;
            7'h12: c = 7'h65;
            7'h21: c = 7'h66;
            7'h22: c = 7'h67;
            7'h23: c = 7'h68;
            7'h17: c = 7'h69;
            7'h24: c = 7'h6A;
            7'h25: c = 7'h6B;
            7'h26: c = 7'h6C;
            7'h32: c = 7'h6D;
            7'h31: c = 7'h6E;
            7'h18: c = 7'h6F;
            7'h19: c = 7'h70;
            7'h10: c = 7'h71;
            7'h13: c = 7'h72;
            7'h1F: c = 7'h73;
            7'h14: c = 7'h74;
            7'h16: c = 7'h75;
            7'h2F: c = 7'h76;
            7'h11: c = 7'h77;
            7'h2D: c = 7'h78;
            7'h15: c = 7'h79;
            7'h2C: c = 7'h7A;  // z
            7'h39: c = 7'h20;  // space
            7'h02: c = 7'h31;  // 1
            7'h03: c = 7'h32;
            7'h04: c = 7'h33;
            7'h1C: c = 7'h0A;  // newline
            7'h0E: c = 7'h08;  // backspace
            7'h34: c = 7'h2E;  // .
            7'h35: c = 7'h2F;  // /
            7'h0C: c = 7'h2D;  // -
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

[rtl/scancode_to_ascii_fifo_top.sv]
// Top level: keyboard scan-code decoder feeding a character ring buffer.
//
// Input channel (i_in_valid / o_in_ready) carries i_op and i_scan_code.
// op 0 delivers one set 1 scan-code byte: it is decoded and a mapped
// character is pushed into the 256-entry buffer; no result beat follows.
// op 1 pops one character; its result beat (o_character, o_empty_res) is
// presented on the output channel (o_out_valid / i_out_ready) in the cycle
// after acceptance. An empty buffer answers character 0 with o_empty_res.
// A full buffer (255 characters) drops new characters.
// Throughput is one item per cycle. The only limit is the single output
// register, fed by the buffer's registered read port: while a result beat
// waits, the input is held off unless that beat leaves in the same cycle.
// Reset (synchronous, active low) clears the extended-prefix flag, the
// buffer indices and the output valid; no clearing pass is needed since
// only written entries are ever read.
module scancode_to_ascii_fifo_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_scan_code,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_character,
    output logic       o_empty_res
);

    logic            in_acc;
    logic            rd_en;
    logic            byte_en;
    logic            r_out_valid;
    sc2a_pkg::t_push push;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign rd_en      = in_acc && (i_op == sc2a_pkg::OP_READ);
    assign byte_en    = in_acc && (i_op == sc2a_pkg::OP_SCAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= rd_en;
        end
    end

    sc2a_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (byte_en),
        .i_code    (i_scan_code),
        .o_push    (push)
    );

    sc2a_ring u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_rd_en     (rd_en),
        .o_character (o_character),
        .o_empty_res (o_empty_res)
    );

    assign o_out_valid = r_out_valid;

endmodule

[rtl/sc2a_decode.sv]
// Scan-code set 1 decoder: extended-prefix flag and make-code mapping.
module sc2a_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_byte_en,
    input  logic [7:0]       i_code,
    output sc2a_pkg::t_push  o_push
);

    logic       r_ext;
    logic [6:0] tab_char;

    assign tab_char = sc2a_pkg::make_char(i_code[6:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext <= 1'b0;
        end else if (i_byte_en) begin
            r_ext <= (i_code == sc2a_pkg::CODE_EXTENDED);
        end
    end

    always_comb begin
        o_push.valid = 1'b0;
        o_push.ch    = sc2a_pkg::CHAR_NONE;
        if (i_byte_en && i_code != sc2a_pkg::CODE_EXTENDED) begin
            if (r_ext) begin
                // after the prefix only the two arrows count
                if (i_code == sc2a_pkg::CODE_UP) begin
                    o_push.valid = 1'b1;
                    o_push.ch    = sc2a_pkg::CHAR_UP;
                end else if (i_code == sc2a_pkg::CODE_DOWN) begin
                    o_push.valid = 1'b1;
                    o_push.ch    = sc2a_pkg::CHAR_DOWN;
                end
            end else if (!i_code[7]) begin
                o_push.valid = (tab_char != sc2a_pkg::CHAR_NONE);
                o_push.ch    = tab_char;
            end
        end
    end

endmodule

[rtl/sc2a_ring.sv]
// Character ring buffer: one store with registered read data, plus indices.
module sc2a_ring (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sc2a_pkg::t_push  i_push,
    input  logic             i_rd_en,
    output logic [6:0]       o_character,
    output logic             o_empty_res
);

    logic [6:0]                 r_mem [sc2a_pkg::BUFFER_DEPTH];
    logic [sc2a_pkg::IDX_W-1:0] r_wr_idx;
    logic [sc2a_pkg::IDX_W-1:0] r_rd_idx;
    logic [sc2a_pkg::IDX_W-1:0] n_wr_idx;
    logic [sc2a_pkg::IDX_W-1:0] n_rd_idx;
    logic [6:0]                 r_q;
    logic                       r_empty;
    logic                       is_empty;
    logic                       is_full;

    assign n_wr_idx = (r_wr_idx == sc2a_pkg::IDX_W'(sc2a_pkg::BUFFER_DEPTH - 1))
                      ? '0 : r_wr_idx + 1'b1;
    assign n_rd_idx = (r_rd_idx == sc2a_pkg::IDX_W'(sc2a_pkg::BUFFER_DEPTH - 1))
                      ? '0 : r_rd_idx + 1'b1;
    assign is_empty = (r_wr_idx == r_rd_idx);
    // one slot kept free; new character dropped when full
    assign is_full  = (n_wr_idx == r_rd_idx);

    always_ff @(posedge i_clk) begin
        if (i_push.valid && !is_full) begin
            r_mem[r_wr_idx] <= i_push.ch;
        end
        if (i_rd_en && !is_empty) begin
            r_q <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_empty  <= 1'b1;
        end else begin
            if (i_push.valid && !is_full) begin
                r_wr_idx <= n_wr_idx;
            end
            if (i_rd_en) begin
                r_empty <= is_empty;
                if (!is_empty) begin
                    r_rd_idx <= n_rd_idx;
                end
            end
        end
    end

    assign o_character = r_empty ? sc2a_pkg::CHAR_NONE : r_q;
    assign o_empty_res = r_empty;

endmodule

[test/tb_scancode_to_ascii_fifo_top.sv]
// Testbench for the scan-code decoder and character ring buffer.
`timescale 1ns / 100ps

module tb_scancode_to_ascii_fifo_top;

    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic [6:0] ch;
        logic       is_empty;
    } t_key_read;

    typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_op        = sc2a_pkg::OP_SCAN;
    logic [7:0] i_scan_code = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [6:0] o_character;
    logic       o_empty_res;

    // keyboard model state
    logic [7:0] keymap [0:127];
    logic [7:0] mapped_codes [$];
    logic [6:0] char_ring [0:sc2a_pkg::BUFFER_DEPTH-1];
    int         wr_idx    = 0;
    int         rd_idx    = 0;
    logic       ext_armed = 1'b0;
    t_key_read  pending_reads [$];

    int cycle_count   = 0;
    int errors        = 0;
    int beats_sent    = 0;
    int burst_left    = 0;
    int chars_stored  = 0;
    int chars_dropped = 0;
    int reads_checked = 0;
    int reads_empty   = 0;

    scancode_to_ascii_fifo_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_scan_code (i_scan_code),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_character (o_character),
        .o_empty_res (o_empty_res)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        foreach (keymap[i]) keymap[i] = 8'h00;
        keymap[7'h1E] = "a";  keymap[7'h30] = "b";  keymap[7'h2E] = "c";
        keymap[7'h20] = "d";  keymap[7'h12] = "e";  keymap[7'h21] = "f";
        keymap[7'h22] = "g";  keymap[7'h23] = "h";  keymap[7'h17] = "i";
        keymap[7'h24] = "j";  keymap[7'h25] = "k";  keymap[7'h26] = "l";
        keymap[7'h32] = "m";  keymap[7'h31] = "n";  keymap[7'h18] = "o";
        keymap[7'h19] = "p";  keymap[7'h10] = "q";  keymap[7'h13] = "r";
        keymap[7'h1F] = "s";  keymap[7'h14] = "t";  keymap[7'h16] = "u";
        keymap[7'h2F] = "v";  keymap[7'h11] = "w";  keymap[7'h2D] = "x";
        keymap[7'h15] = "y";  keymap[7'h2C] = "z";  keymap[7'h39] = " ";
        keymap[7'h02] = "1";  keymap[7'h03] = "2";  keymap[7'h04] = "3";
        keymap[7'h1C] = 8'h0A;  // newline
        keymap[7'h0E] = 8'h08;  // backspace
        keymap[7'h34] = ".";  keymap[7'h35] = "/";  keymap[7'h0C] = "-";
        foreach (keymap[i]) begin
            if (keymap[i] != 8'h00) mapped_codes.push_back(8'(i));
        end
    end

    task automatic buffer_char(input logic [6:0] c);
        // one slot always kept free, so a full ring drops the newcomer
        if ((wr_idx + 1) % sc2a_pkg::BUFFER_DEPTH == rd_idx) begin
            chars_dropped++;
        end else begin
            char_ring[wr_idx] = c;
            wr_idx = (wr_idx + 1) % sc2a_pkg::BUFFER_DEPTH;
            chars_stored++;
        end
    endtask

    task automatic track_beat(input logic op, input logic [7:0] code);
        t_key_read r;
        if (op == sc2a_pkg::OP_READ) begin
            if (wr_idx == rd_idx) begin
                r.ch       = sc2a_pkg::CHAR_NONE;
                r.is_empty = 1'b1;
            end else begin
                r.ch       = char_ring[rd_idx];
                r.is_empty = 1'b0;
                rd_idx     = (rd_idx + 1) % sc2a_pkg::BUFFER_DEPTH;
            end
            pending_reads.push_back(r);
        end else if (code == sc2a_pkg::CODE_EXTENDED) begin
            ext_armed = 1'b1;
        end else if (ext_armed) begin
            ext_armed = 1'b0;
            if (code == sc2a_pkg::CODE_UP) buffer_char(sc2a_pkg::CHAR_UP);
            else if (code == sc2a_pkg::CODE_DOWN) buffer_char(sc2a_pkg::CHAR_DOWN);
        end else if (code[7] == 1'b0 && keymap[code[6:0]] != 8'h00) begin
            // make code with a table entry; release codes have bit 7 set
            buffer_char(keymap[code[6:0]][6:0]);
        end
    endtask

    // result check first, then prediction of the beat accepted at this edge
    always @(posedge i_clk) begin
        t_key_read want;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (pending_reads.size() == 0) begin
                    $error("unexpected result beat: character %0h empty_res %0b",
                           o_character, o_empty_res);
                    errors++;
                end else begin
                    want = pending_reads.pop_front();
                    reads_checked++;
                    if (want.is_empty) reads_empty++;
                    if (o_character !== want.ch) begin
                        $error("character: expected %0h, actual %0h", want.ch, o_character);
                        errors++;
                    end
                    if (o_empty_res !== want.is_empty) begin
                        $error("empty_res: expected %0b, actual %0b",
                               want.is_empty, o_empty_res);
                        errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) track_beat(i_op, i_scan_code);
        end
    end

    // receiver back-pressure, switching between patterns
    always @(posedge i_clk) begin
        static t_rx_mode rx_mode   = RX_OPEN;
        static int       rx_left   = 0;
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(32, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_MOSTLY: i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
            default:   i_out_ready <= ((cycle_count % 16) < 6);
        endcase
    end

    task automatic send_beat(input logic op, input logic [7:0] code);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_scan_code <= code;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
    endtask

    task automatic read_char();
        send_beat(sc2a_pkg::OP_READ, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reads.size() != 0);
    endtask

    function automatic logic [7:0] random_key();
        return mapped_codes[$urandom_range(0, mapped_codes.size() - 1)];
    endfunction

    task automatic test_empty_read();
        read_char();
    endtask

    task automatic test_make_and_release();
        send_beat(sc2a_pkg::OP_SCAN, 8'h1E);
        send_beat(sc2a_pkg::OP_SCAN, 8'h00);
        send_beat(sc2a_pkg::OP_SCAN, 8'h7F);
        send_beat(sc2a_pkg::OP_SCAN, 8'h80);
        send_beat(sc2a_pkg::OP_SCAN, 8'hFF);
        send_beat(sc2a_pkg::OP_SCAN, 8'h9E);  // release of the same key
        send_beat(sc2a_pkg::OP_SCAN, 8'h39);
        repeat (3) read_char();
    endtask

    task automatic test_extended_prefix();
        send_beat(sc2a_pkg::OP_SCAN, sc2a_pkg::CODE_EXTENDED);
        send_beat(sc2a_pkg::OP_SCAN, sc2a_pkg::CODE_UP);
        // prefix repeated before the arrow
        send_beat(sc2a_pkg::OP_SCAN, sc2a_pkg::CODE_EXTENDED);
        send_beat(sc2a_pkg::OP_SCAN, sc2a_pkg::CODE_EXTENDED);
        send_beat(sc2a_pkg::OP_SCAN, sc2a_pkg::CODE_DOWN);
        // a released or ordinary key after the prefix is swallowed
        send_beat(sc2a_pkg::OP_SCAN, sc2a_pkg::CODE_EXTENDED);
        send_beat(sc2a_pkg::OP_SCAN, 8'h9E);
        send_beat(sc2a_pkg::OP_SCAN, sc2a_pkg::CODE_EXTENDED);
        send_beat(sc2a_pkg::OP_SCAN, 8'h1E);
        send_beat(sc2a_pkg::OP_SCAN, sc2a_pkg::CODE_UP);  // no prefix: unmapped
        repeat (3) read_char();
        wait_drained();
    endtask

    task automatic test_full_buffer();
        repeat (sc2a_pkg::BUFFER_DEPTH + 4) send_beat(sc2a_pkg::OP_SCAN, random_key());
        repeat (sc2a_pkg::BUFFER_DEPTH + 1) read_char();
    endtask

    task automatic test_random_typing(input int n_items);
        int         sent;
        int         phase_left;
        int         read_pct;
        int         pick;
        logic [7:0] follow;
        sent       = 0;
        phase_left = 0;
        read_pct   = 30;
        while (sent < n_items) begin
            if (phase_left <= 0) begin
                case ($urandom_range(0, 2))
                    0:       read_pct = 10;
                    1:       read_pct = 35;
                    default: read_pct = 60;
                endcase
                phase_left = $urandom_range(60, 180);
            end
            if ($urandom_range(0, 299) == 0) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < read_pct) begin
                read_char();
                sent++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    send_beat(sc2a_pkg::OP_SCAN, random_key());
                    sent++;
                end else if (pick < 78) begin
                    send_beat(sc2a_pkg::OP_SCAN, random_key() | 8'h80);
                    sent++;
                end else if (pick < 90) begin
                    case ($urandom_range(0, 5))
                        0:       follow = sc2a_pkg::CODE_UP;
                        1:       follow = sc2a_pkg::CODE_DOWN;
                        2:       follow = sc2a_pkg::CODE_UP | 8'h80;
                        3:       follow = sc2a_pkg::CODE_DOWN | 8'h80;
                        4:       follow = sc2a_pkg::CODE_EXTENDED;
                        default: follow = 8'($urandom_range(0, 255));
                    endcase
                    send_beat(sc2a_pkg::OP_SCAN, sc2a_pkg::CODE_EXTENDED);
                    send_beat(sc2a_pkg::OP_SCAN, follow);
                    sent += 2;
                end else begin
                    send_beat(sc2a_pkg::OP_SCAN, 8'($urandom_range(0, 255)));
                    sent++;
                end
            end
            phase_left--;
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_scancode_to_ascii_fifo_top NOT OK");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_read();
        test_make_and_release();
        test_extended_prefix();
        test_full_buffer();
        test_random_typing(1110);
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("%0d beats sent: %0d characters buffered, %0d dropped on a full ring",
                 beats_sent, chars_stored, chars_dropped);
        $display("%0d reads checked, %0d of them on an empty ring", reads_checked, reads_empty);
        if (errors == 0) begin
            $display("tb_scancode_to_ascii_fifo_top OK");
        end else begin
            $display("tb_scancode_to_ascii_fifo_top NOT OK");
        end
        $finish;
    end

endmodule
